// ===== src/lcb_pkg.sv =====
// ---------------------------------------------------------------------------
// lcb_pkg
// Shared constants and helpers for the layer compositor blend block.
// ---------------------------------------------------------------------------
package lcb_pkg;

    localparam int IN_W  = 104;
    localparam int OUT_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISPCNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BGPRIO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLDCNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLDWT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BACKDROP = 3'd7;

    // layer codes
    localparam logic [2:0] LAYER_SPRITE   = 3'd4;
    localparam logic [2:0] LAYER_BACKDROP = 3'd5;

    // effect / action codes
    localparam logic [1:0] FX_NONE    = 2'd0;
    localparam logic [1:0] FX_ALPHA   = 2'd1;
    localparam logic [1:0] FX_BRIGHT  = 2'd2;
    localparam logic [1:0] FX_DARK    = 2'd3;

    // horizontal or vertical span test; inverted edges wrap
    function automatic logic span_hit(input logic [7:0] lo, input logic [7:0] hi,
                                      input logic [7:0] p);
        if (lo <= hi) return (p >= lo) && (p < hi);
        return (p >= lo) || (p < hi);
    endfunction

    function automatic logic [4:0] cap16(input logic [4:0] v);
        return (v > 5'd16) ? 5'd16 : v;
    endfunction

endpackage

// ===== src/layer_compositor_blend.sv =====
// ---------------------------------------------------------------------------
// layer_compositor_blend
// Window select, layer sort and color effects for one pixel per cycle while the receiver does not stall.
// ---------------------------------------------------------------------------
// Usage:
//  Slave stream carries one pixel per beat; tdata from the lowest bit:
//  line, column, bg0..bg3 pixels, sprite pixel, sprite priority, semi
//  transparent flag, object window flag (zero filled to 104 bits).
//  Master stream returns color and top layer per beat.
//  Config writes (i_cfg_we/i_cfg_idx/i_cfg_data) are taken at any edge
//  with the enable high and must happen while the pipe is empty.
//  Four register stages: window select, layer sort, per-channel products,
//  sum/round/clamp. The accepting edge loads stage one; the beat then moves
//  through stages two, three and four before m_axis_tvalid rises. Throughput
//  is one pixel per cycle while the receiver does not stall, as every stage takes a new beat each cycle.
//  When the receiver stalls, full stages hold and empty stages ahead of
//  them still fill; s_axis_tready falls only when all four stages are full
//  and the output beat is not taken, so nothing is lost.
//  Reset clears valid bits and all config registers to zero.
// ---------------------------------------------------------------------------
module layer_compositor_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lcb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: line, column, bg0..bg3, sprite pixel, sprite prio, semi, objwin
    input  logic [lcb_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: color[14:0], top_layer[17:15], zero fill
    output logic [lcb_pkg::OUT_W-1:0]     m_axis_tdata
);
    import lcb_pkg::*;

    // config registers
    logic [15:0] r_dispcnt;
    logic [7:0]  r_bgprio;
    logic [31:0] r_win0, r_win1, r_winen;
    logic [13:0] r_bldcnt;
    logic [14:0] r_bldwt, r_backdrop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dispcnt <= '0; r_bgprio <= '0; r_win0 <= '0; r_win1 <= '0;
            r_winen <= '0; r_bldcnt <= '0; r_bldwt <= '0; r_backdrop <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DISPCNT:  r_dispcnt  <= i_cfg_data[15:0];
                REG_BGPRIO:   r_bgprio   <= i_cfg_data[7:0];
                REG_WIN0:     r_win0     <= i_cfg_data;
                REG_WIN1:     r_win1     <= i_cfg_data;
                REG_WINEN:    r_winen    <= i_cfg_data;
                REG_BLDCNT:   r_bldcnt   <= i_cfg_data[13:0];
                REG_BLDWT:    r_bldwt    <= i_cfg_data[14:0];
                REG_BACKDROP: r_backdrop <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline enables: a stage moves when the next can take it
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    assign en4 = !r_v4 || m_axis_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // input unpack
    logic [7:0]  in_y, in_x;
    logic [15:0] in_px [5];
    assign in_y = s_axis_tdata[7:0];
    assign in_x = s_axis_tdata[15:8];
    for (genvar g = 0; g < 5; g++) begin : g_px
        assign in_px[g] = s_axis_tdata[16+16*g +: 16];
    end

    // stage 1: window mask
    logic [5:0] n_wm;
    always_comb begin
        logic [2:0] wins;
        wins = r_dispcnt[15:13];
        if (wins == 3'd0) n_wm = 6'h3F;
        else if (wins[0] && span_hit(r_win0[7:0], r_win0[15:8], in_x)
                 && span_hit(r_win0[23:16], r_win0[31:24], in_y))
            n_wm = r_winen[5:0];
        else if (wins[1] && span_hit(r_win1[7:0], r_win1[15:8], in_x)
                 && span_hit(r_win1[23:16], r_win1[31:24], in_y))
            n_wm = r_winen[13:8];
        else if (wins[2] && s_axis_tdata[99]) n_wm = r_winen[29:24];
        else n_wm = r_winen[21:16];
    end

    logic [5:0]  r1_wm;
    logic [15:0] r1_px [5];
    logic [1:0]  r1_sprio;
    logic        r1_semi;
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_wm <= n_wm;
            for (int k = 0; k < 5; k++) r1_px[k] <= in_px[k];
            r1_sprio <= s_axis_tdata[97:96];
            r1_semi  <= s_axis_tdata[98];
        end
    end

    // stage 2: sort to top and low, pick action
    logic [2:0]  n_top, n_low;
    logic [1:0]  n_act;
    logic [14:0] n_ca, n_cb;
    always_comb begin
        logic [4:0] vis;
        logic [1:0] prio [5];
        logic [2:0] mode;
        logic [1:0] cnt;
        logic partner;
        logic isfirst;
        mode = r_dispcnt[2:0];
        vis[0] = r_dispcnt[8] && (mode < 3'd2);
        vis[1] = r_dispcnt[9] && (mode < 3'd2);
        vis[2] = r_dispcnt[10];
        vis[3] = r_dispcnt[11] && (mode == 3'd0 || mode == 3'd2);
        vis[4] = r_dispcnt[12];
        for (int k = 0; k < 5; k++) vis[k] = vis[k] && r1_wm[k] && r1_px[k][15];
        for (int k = 0; k < 4; k++) prio[k] = r_bgprio[2*k +: 2];
        prio[4] = r1_sprio;
        n_top = LAYER_BACKDROP;
        n_low = LAYER_BACKDROP;
        cnt = 2'd0;
        // scan priority levels, sprite first then bg by index
        for (int p = 0; p < 4; p++) begin
            for (int j = 0; j < 5; j++) begin
                int k;
                k = (j == 0) ? 4 : j - 1;
                if (vis[k] && prio[k] == p[1:0]) begin
                    if (cnt == 2'd0) n_top = 3'(k);
                    else if (cnt == 2'd1) n_low = 3'(k);
                    if (cnt != 2'd2) cnt = cnt + 2'd1;
                end
            end
        end
        n_ca = (n_top == LAYER_BACKDROP) ? r_backdrop : r1_px[n_top][14:0];
        n_cb = (n_low == LAYER_BACKDROP) ? r_backdrop : r1_px[n_low][14:0];
        isfirst = r_bldcnt[n_top];
        partner = (n_top != LAYER_BACKDROP) && r_bldcnt[8 + n_low];
        n_act = FX_NONE;
        if (r1_wm[5]) begin
            if (n_top == LAYER_SPRITE && r1_semi && partner) n_act = FX_ALPHA;
            else if (isfirst) begin
                if (r_bldcnt[7:6] == FX_ALPHA) begin
                    if (partner && !(n_top == LAYER_SPRITE && r1_semi))
                        n_act = FX_ALPHA;
                end else n_act = r_bldcnt[7:6];
            end
        end
    end

    logic [2:0]  r2_top;
    logic [1:0]  r2_act;
    logic [14:0] r2_ca, r2_cb;
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_top <= n_top; r2_act <= n_act; r2_ca <= n_ca; r2_cb <= n_cb;
        end
    end

    // stage 3: per-channel products
    logic [9:0] n_pa [3], n_pb [3];
    always_comb begin
        logic [4:0] wa, wb, f, a, b;
        wa = cap16(r_bldwt[4:0]);
        wb = cap16(r_bldwt[9:5]);
        f  = cap16(r_bldwt[14:10]);
        for (int k = 0; k < 3; k++) begin
            a = r2_ca[5*k +: 5];
            b = r2_cb[5*k +: 5];
            unique case (r2_act)
                FX_ALPHA:  begin n_pa[k] = a * wa; n_pb[k] = b * wb; end
                FX_BRIGHT: begin n_pa[k] = (5'd31 - a) * f; n_pb[k] = '0; end
                FX_DARK:   begin n_pa[k] = a * f; n_pb[k] = '0; end
                default:   begin n_pa[k] = '0; n_pb[k] = '0; end
            endcase
        end
    end

    logic [2:0]  r3_top;
    logic [1:0]  r3_act;
    logic [14:0] r3_ca;
    logic [9:0]  r3_pa [3], r3_pb [3];
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_top <= r2_top; r3_act <= r2_act; r3_ca <= r2_ca;
            r3_pa <= n_pa; r3_pb <= n_pb;
        end
    end

    // stage 4: round, clamp and pack
    logic [14:0] n_col;
    always_comb begin
        logic [10:0] s;
        logic [4:0]  a;
        n_col = r3_ca;
        for (int k = 0; k < 3; k++) begin
            a = r3_ca[5*k +: 5];
            unique case (r3_act)
                FX_ALPHA: begin
                    s = ({1'b0, r3_pa[k]} + {1'b0, r3_pb[k]} + 11'd8) >> 4;
                    n_col[5*k +: 5] = (s > 11'd31) ? 5'd31 : s[4:0];
                end
                FX_BRIGHT: begin
                    s = ({1'b0, r3_pa[k]} + 11'd8) >> 4;
                    n_col[5*k +: 5] = a + s[4:0];
                end
                FX_DARK: begin
                    s = ({1'b0, r3_pa[k]} + 11'd7) >> 4;
                    n_col[5*k +: 5] = a - s[4:0];
                end
                default: s = '0;
            endcase
        end
    end

    logic [14:0] r4_col;
    logic [2:0]  r4_top;
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_col <= n_col; r4_top <= r3_top;
        end
    end

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {6'd0, r4_top, r4_col};

endmodule

// ===== src/lcb_checker.sv =====
// ---------------------------------------------------------------------------
// lcb_checker
// Port-level checks of the layer compositor blend stream behavior.
// ---------------------------------------------------------------------------
module lcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    import lcb_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // top layer code stays in range
    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:15] <= LAYER_BACKDROP)
        else $error("bad top layer");

    // output side free means input side ready
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready with empty output");

    // an empty pipe after reset shows no result
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");

endmodule

bind layer_compositor_blend lcb_checker u_lcb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
